@@ sv/ancx_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ancx_pkg: shared types and constants of the caption CDP extractor
// Parse phases, result beat layout, status codes and CDP constants.
// ----------------------------------------------------------------------------
package ancx_pkg;

  // Configuration register indexes
  localparam logic CFG_IDX_DID  = 1'b0;
  localparam logic CFG_IDX_SDID = 1'b1;

  localparam logic [7:0] DID_RESET  = 8'd97;
  localparam logic [7:0] SDID_RESET = 8'd1;

  // Status codes
  localparam logic [1:0] ST_CAPTIONS = 2'd0;
  localparam logic [1:0] ST_NOT_CAP  = 2'd1;
  localparam logic [1:0] ST_BAD_ID   = 2'd2;
  localparam logic [1:0] ST_SHORT    = 2'd3;

  // Result kinds
  localparam logic KIND_CAPTION = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // CDP constants
  localparam logic [15:0] CDP_IDENT   = 16'h9669;
  localparam logic [7:0]  SECT_TC     = 8'h71;
  localparam logic [7:0]  SECT_CC     = 8'h72;
  localparam logic [7:0]  HDR_LAST_P  = 8'd6;   // last header payload offset
  localparam logic [7:0]  TC_LAST_P   = 8'd11;  // last time-code payload offset
  localparam logic [8:0]  IDX_COUNT   = 9'd2;
  localparam logic [8:0]  IDX_PAYLOAD = 9'd3;

  // Output queue
  localparam int OQ_DEPTH = 3;
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  typedef enum logic [11:0] {
    PH_IDLE    = 12'b0000_0000_0001,
    PH_SDID    = 12'b0000_0000_0010,
    PH_COUNT   = 12'b0000_0000_0100,
    PH_ID_HI   = 12'b0000_0000_1000,
    PH_ID_LO   = 12'b0000_0001_0000,
    PH_HDR     = 12'b0000_0010_0000,
    PH_SECT1   = 12'b0000_0100_0000,
    PH_TC      = 12'b0000_1000_0000,
    PH_SECT2   = 12'b0001_0000_0000,
    PH_CCCOUNT = 12'b0010_0000_0000,
    PH_CAPT    = 12'b0100_0000_0000,
    PH_DONE    = 12'b1000_0000_0000
  } phase_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] caption_byte;
    logic [1:0] status_code;
    logic [4:0] triple_count;
    logic [7:0] packet_checksum;
    logic       last_of_packet;
  } result_t;

  // Up to two result beats produced by one input beat, in order
  typedef struct packed {
    logic    v0;
    result_t r0;
    logic    v1;
    result_t r1;
  } push_t;

endpackage

@@ sv/ancx_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ancx_parser: ANC packet walker and CDP parser
// Tracks one packet byte per accepted beat and emits caption/status results.
// ----------------------------------------------------------------------------
module ancx_parser (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fire,
  input  logic [7:0]      data_byte,
  input  logic            packet_start,
  input  logic [7:0]      caption_did,
  input  logic [7:0]      caption_sdid,
  output ancx_pkg::push_t push
);
  import ancx_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [8:0] bidx_r, bidx_nxt;
  logic [7:0] plen_r, plen_nxt;
  logic       is_cap_r, is_cap_nxt;
  logic [7:0] id_hi_r, id_hi_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [4:0] triples_r, triples_nxt;
  logic [6:0] left_r, left_nxt;
  logic [1:0] fstat_r, fstat_nxt;

  logic [7:0] p;
  logic [8:0] p1;
  logic [4:0] cc;
  logic [6:0] cc3;
  logic [8:0] rem;
  logic       emit;
  logic [1:0] st;
  result_t    cap_res, st_res;

  assign p   = 8'(bidx_r - IDX_PAYLOAD);
  assign p1  = {1'b0, p} + 9'd1;
  assign cc  = data_byte[4:0];
  assign cc3 = 7'({2'b00, cc} + {1'b0, cc, 1'b0});
  assign rem = {1'b0, plen_r} - p1;

  always_comb begin
    phase_nxt   = phase_r;
    bidx_nxt    = bidx_r;
    plen_nxt    = plen_r;
    is_cap_nxt  = is_cap_r;
    id_hi_nxt   = id_hi_r;
    sum_nxt     = sum_r;
    triples_nxt = triples_r;
    left_nxt    = left_r;
    fstat_nxt   = fstat_r;
    emit        = 1'b0;
    push        = '0;

    cap_res              = '0;
    cap_res.result_kind  = KIND_CAPTION;
    cap_res.caption_byte = data_byte;

    if (fire) begin
      if (packet_start) begin
        bidx_nxt    = 9'd1;
        sum_nxt     = data_byte;
        is_cap_nxt  = (data_byte == caption_did);
        id_hi_nxt   = '0;
        triples_nxt = '0;
        left_nxt    = '0;
        fstat_nxt   = ST_CAPTIONS;
        plen_nxt    = '0;
        phase_nxt   = PH_SDID;
      end else if (phase_r != PH_IDLE) begin
        sum_nxt = sum_r + data_byte;
        if (phase_r == PH_SDID) begin
          if (data_byte != caption_sdid) is_cap_nxt = 1'b0;
          bidx_nxt  = IDX_COUNT;
          phase_nxt = PH_COUNT;
        end else if (phase_r == PH_COUNT) begin
          plen_nxt = data_byte;
          bidx_nxt = IDX_PAYLOAD;
          if (is_cap_r) begin
            phase_nxt = PH_ID_HI;
          end else begin
            fstat_nxt = ST_NOT_CAP;
            phase_nxt = PH_DONE;
          end
          emit = (data_byte == 8'd0);
        end else begin
          bidx_nxt = bidx_r + 9'd1;
          unique case (phase_r)
            PH_ID_HI: begin
              id_hi_nxt = data_byte;
              phase_nxt = PH_ID_LO;
            end
            PH_ID_LO: begin
              if ({id_hi_r, data_byte} != CDP_IDENT) begin
                fstat_nxt = ST_BAD_ID;
                phase_nxt = PH_DONE;
              end else begin
                phase_nxt = PH_HDR;
              end
            end
            PH_HDR: begin
              if (p >= HDR_LAST_P) phase_nxt = PH_SECT1;
            end
            PH_SECT1: begin
              if (data_byte == SECT_TC) begin
                phase_nxt = PH_TC;
              end else if (data_byte == SECT_CC) begin
                phase_nxt = PH_CCCOUNT;
              end else begin
                fstat_nxt = ST_NOT_CAP;
                phase_nxt = PH_DONE;
              end
            end
            PH_TC: begin
              if (p >= TC_LAST_P) phase_nxt = PH_SECT2;
            end
            PH_SECT2: begin
              if (data_byte == SECT_CC) begin
                phase_nxt = PH_CCCOUNT;
              end else begin
                fstat_nxt = ST_NOT_CAP;
                phase_nxt = PH_DONE;
              end
            end
            PH_CCCOUNT: begin
              if (({1'b0, plen_r} < p1) || (rem < {2'b00, cc3})) begin
                fstat_nxt = ST_SHORT;
                phase_nxt = PH_DONE;
              end else begin
                triples_nxt = cc;
                left_nxt    = cc3;
                if (cc == 5'd0) begin
                  fstat_nxt = ST_CAPTIONS;
                  phase_nxt = PH_DONE;
                end else begin
                  phase_nxt = PH_CAPT;
                end
              end
            end
            PH_CAPT: begin
              push.v0  = 1'b1;
              push.r0  = cap_res;
              left_nxt = left_r - 7'd1;
              if (left_r == 7'd1) begin
                fstat_nxt = ST_CAPTIONS;
                phase_nxt = PH_DONE;
              end
            end
            PH_DONE: begin
            end
            default: begin
            end
          endcase
          emit = (p1 >= {1'b0, plen_r});
        end
      end
    end

    // status resolves from the phase reached on this byte
    unique case (phase_nxt) inside
      PH_DONE:            st = fstat_nxt;
      PH_ID_HI, PH_ID_LO: st = ST_BAD_ID;
      PH_CCCOUNT:         st = ST_SHORT;
      PH_CAPT:            st = ST_CAPTIONS;
      default:            st = ST_NOT_CAP;
    endcase

    st_res                 = '0;
    st_res.result_kind     = KIND_STATUS;
    st_res.status_code     = st;
    st_res.triple_count    = (st == ST_CAPTIONS) ? triples_nxt : 5'd0;
    st_res.packet_checksum = sum_nxt;
    st_res.last_of_packet  = 1'b1;

    if (emit) begin
      phase_nxt = PH_IDLE;
      if (push.v0) begin
        push.v1 = 1'b1;
        push.r1 = st_res;
      end else begin
        push.v0 = 1'b1;
        push.r0 = st_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      bidx_r    <= '0;
      plen_r    <= '0;
      is_cap_r  <= 1'b0;
      id_hi_r   <= '0;
      sum_r     <= '0;
      triples_r <= '0;
      left_r    <= '0;
      fstat_r   <= ST_CAPTIONS;
    end else begin
      phase_r   <= phase_nxt;
      bidx_r    <= bidx_nxt;
      plen_r    <= plen_nxt;
      is_cap_r  <= is_cap_nxt;
      id_hi_r   <= id_hi_nxt;
      sum_r     <= sum_nxt;
      triples_r <= triples_nxt;
      left_r    <= left_nxt;
      fstat_r   <= fstat_nxt;
    end
  end

endmodule

@@ sv/ancx_out_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ancx_out_queue: small result queue
// Takes up to two beats per cycle; hands one per cycle from head if out_ready.
// ----------------------------------------------------------------------------
module ancx_out_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  ancx_pkg::push_t   push,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output ancx_pkg::result_t head
);
  import ancx_pkg::*;

  result_t             ent_r   [OQ_DEPTH];
  result_t             ent_nxt [OQ_DEPTH];
  logic [OQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [OQ_CNT_W-1:0] cnt_p;
  logic                pop;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  assign head      = ent_r[0];
  // room for a two-beat push whatever the output side does
  assign room      = (cnt_r <= OQ_CNT_W'(OQ_DEPTH - 2));
  assign cnt_p     = cnt_r - OQ_CNT_W'(pop);

  always_comb begin
    for (int i = 0; i < OQ_DEPTH - 1; i++) begin
      ent_nxt[i] = pop ? ent_r[i+1] : ent_r[i];
    end
    ent_nxt[OQ_DEPTH-1] = ent_r[OQ_DEPTH-1];
    for (int i = 0; i < OQ_DEPTH; i++) begin
      if (push.v0 && (cnt_p == OQ_CNT_W'(i))) ent_nxt[i] = push.r0;
      if (push.v1 && ((cnt_p + OQ_CNT_W'(1)) == OQ_CNT_W'(i))) ent_nxt[i] = push.r1;
    end
    cnt_nxt = cnt_p + OQ_CNT_W'(push.v0) + OQ_CNT_W'(push.v1);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < OQ_DEPTH; i++) begin
      ent_r[i] <= ent_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ sv/anc_caption_cdp_extractor_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anc_caption_cdp_extractor_unit: caption data extractor for 8-bit ANC packets
// Walks DID, SDID, count and payload; on a caption packet parses the CDP and
// passes the cc_data triples, then closes each packet with one status beat.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  in_     | input     | in_valid / in_ready  | data_byte, packet_start
//  out_    | output    | out_valid / out_ready| kind, byte, status, count, sum
//  cfg_    | input     | cfg_valid / cfg_ready| index (0 DID, 1 SDID), data
//
//  One byte is taken per cycle while in_ready is high; its results are
//  written into the output queue at the accepting edge, so the first can
//  leave in the next cycle. A caption byte that also ends the payload
//  yields two beats. in_ready drops only when the 3-entry output queue
//  cannot take two more beats, i.e. while the output side is stalled or
//  draining a double beat. Reset (rst_n, synchronous, active low) empties
//  the queue, returns the parser to idle and loads DID 0x61 / SDID 0x01.
//  cfg_ready is always high.
module anc_caption_cdp_extractor_unit (
  input  logic       clk,
  input  logic       rst_n,
  // input beats
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_packet_start,
  // result beats
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_result_kind,
  output logic [7:0] out_caption_byte,
  output logic [1:0] out_status_code,
  output logic [4:0] out_triple_count,
  output logic [7:0] out_packet_checksum,
  output logic       out_last_of_packet,
  // configuration writes
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);
  import ancx_pkg::*;

  logic [7:0] did_r;
  logic [7:0] sdid_r;
  logic       in_fire;
  push_t      push;
  result_t    head;

  assign cfg_ready = 1'b1;

  // Caption match registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      did_r  <= DID_RESET;
      sdid_r <= SDID_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_IDX_DID:  did_r  <= cfg_data;
        CFG_IDX_SDID: sdid_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_fire = in_valid && in_ready;

  // Per-byte parse: state registers plus combinational decode logic
  ancx_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (in_fire),
    .data_byte    (in_data_byte),
    .packet_start (in_packet_start),
    .caption_did  (did_r),
    .caption_sdid (sdid_r),
    .push         (push)
  );

  // Result queue decouples the two sides
  ancx_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_result_kind     = head.result_kind;
  assign out_caption_byte    = head.caption_byte;
  assign out_status_code     = head.status_code;
  assign out_triple_count    = head.triple_count;
  assign out_packet_checksum = head.packet_checksum;
  assign out_last_of_packet  = head.last_of_packet;

endmodule
